// File: rtl/hhp_pkg.sv
// Package for the HTTP head parser: payload structs, result kinds, error codes.
// No dependencies.
package hhp_pkg;

  localparam int unsigned POS_BITS_DEF = 16;

  typedef struct packed {
    logic [7:0] byte_req;
    logic       last;
  } hhp_in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  error_code;
    logic [3:0]  method;
    logic [1:0]  version;
    logic [9:0]  status_num;
    logic [15:0] span_offset;
    logic [15:0] span_length;
    logic [15:0] value_offset;
    logic [15:0] value_length;
    logic [7:0]  header_count;
    logic [15:0] body_offset;
  } hhp_out_t;

  // Byte tagged with its message position, passed from front to back.
  typedef struct packed {
    logic [7:0]  byte_req;
    logic        last;
    logic [31:0] pos;
  } hhp_tok_t;

  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_FIELD = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;
  localparam logic [1:0] KIND_ERR   = 2'd3;

  localparam logic [2:0] ERR_METHOD = 3'd1;
  localparam logic [2:0] ERR_URL    = 3'd2;
  localparam logic [2:0] ERR_VER    = 3'd3;
  localparam logic [2:0] ERR_STATUS = 3'd4;
  localparam logic [2:0] ERR_SEP    = 3'd5;
  localparam logic [2:0] ERR_COLON  = 3'd6;
  localparam logic [2:0] ERR_TRUNC  = 3'd7;

  localparam logic [0:0] REG_MODE   = 1'b0;
  localparam logic [0:0] REG_FIELDS = 1'b1;

  // Character of method m at index i, 0 past its end.
  function automatic logic [7:0] method_char(input int m, input logic [2:0] i);
    logic [7:0] s [0:8][0:6];
    s[0] = '{"G","E","T",0,0,0,0};
    s[1] = '{"P","O","S","T",0,0,0};
    s[2] = '{"H","E","A","D",0,0,0};
    s[3] = '{"P","U","T",0,0,0,0};
    s[4] = '{"D","E","L","E","T","E",0};
    s[5] = '{"C","O","N","N","E","C","T"};
    s[6] = '{"O","P","T","I","O","N","S"};
    s[7] = '{"T","R","A","C","E",0,0};
    s[8] = '{"P","A","T","C","H",0,0};
    return s[m][i];
  endfunction

  function automatic logic [2:0] method_len(input int m);
    logic [2:0] l [0:8];
    l = '{3'd3, 3'd4, 3'd4, 3'd3, 3'd6, 3'd7, 3'd7, 3'd5, 3'd5};
    return l[m];
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

endpackage

// File: rtl/http_head_parser_unit.sv
// Channel   Signals                                  Direction
// in        in_valid, in_ready, in_data (hhp_in_t)   byte stream in
// out       out_valid, out_ready, out_data           results out
// cfg       cfg_we, cfg_index, cfg_wdata             register writes
// One byte per cycle while the output is not stalled. A result passes through the front
// queue and then the engine's output register before it is offered.
// Throughput is set by the engine's state update. Reset is synchronous;
// a stalled output holds the queue and, when full, the input. No clearing pass.
// Top level of the HTTP head parser. Depends on hhp_pkg and its submodules.
module http_head_parser_unit #(
  parameter int unsigned POS_BITS = hhp_pkg::POS_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  hhp_pkg::hhp_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output hhp_pkg::hhp_out_t out_data,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic              cfg_wdata
);
  import hhp_pkg::*;

  hhp_tok_t f_data, q_data;
  logic     f_valid, f_ready, q_valid, q_ready;
  logic     mode_r, fields_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0; fields_r <= 1'b1;
    end else if (cfg_we) begin
      if (cfg_index == REG_MODE) mode_r <= cfg_wdata;
      else fields_r <= cfg_wdata;
    end
  end

  hhp_front #(.POS_BITS(POS_BITS)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .tok_valid(f_valid), .tok_ready(f_ready), .tok_data(f_data));

  hhp_fifo u_fifo (
    .clk, .rst_n, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data));

  hhp_engine #(.POS_BITS(POS_BITS)) u_engine (
    .clk, .rst_n, .tok_valid(q_valid), .tok_ready(q_ready), .tok_data(q_data),
    .parse_mode(mode_r), .field_results(fields_r),
    .out_valid, .out_ready, .out_data);
endmodule

// File: rtl/hhp_front.sv
// Front end: accepts bytes, tags each with its saturating message position.
// Depends on hhp_pkg.
module hhp_front #(
  parameter int unsigned POS_BITS = hhp_pkg::POS_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  hhp_pkg::hhp_in_t in_data,
  output logic             tok_valid,
  input  logic             tok_ready,
  output hhp_pkg::hhp_tok_t tok_data
);
  import hhp_pkg::*;

  logic [POS_BITS-1:0] pos_r, pos_nxt;
  logic                take;

  assign in_ready  = tok_ready;
  assign tok_valid = in_valid;
  assign take      = in_valid && tok_ready;

  always_comb begin
    tok_data.byte_req = in_data.byte_req;
    tok_data.last     = in_data.last;
    tok_data.pos      = 32'(pos_r);
    pos_nxt = pos_r;
    if (take) begin
      if (in_data.last) pos_nxt = '0;
      else if (pos_r != '1) pos_nxt = pos_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) pos_r <= '0;
    else pos_r <= pos_nxt;
  end
endmodule

// File: rtl/hhp_fifo.sv
// Two-entry queue between front end and parse engine.
// Depends on hhp_pkg.
module hhp_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  hhp_pkg::hhp_tok_t wr_data,
  output logic              rd_valid,
  input  logic              rd_ready,
  output hhp_pkg::hhp_tok_t rd_data
);
  import hhp_pkg::*;

  hhp_tok_t   mem_r [0:1];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr, rd;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data  = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= ~wp_r;
      if (rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(wr) - 2'(rd);
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0) |-> !rd)
    else $error("read from empty queue");
endmodule

// File: rtl/hhp_engine.sv
// Parse engine: runs the head state machine on queued bytes, registers results.
// Depends on hhp_pkg.
module hhp_engine #(
  parameter int unsigned POS_BITS = hhp_pkg::POS_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              tok_valid,
  output logic              tok_ready,
  input  hhp_pkg::hhp_tok_t tok_data,
  input  logic              parse_mode,
  input  logic              field_results,
  output logic              out_valid,
  input  logic              out_ready,
  output hhp_pkg::hhp_out_t out_data
);
  import hhp_pkg::*;

  typedef enum logic [4:0] {
    P_START, P_METHOD, P_URL, P_URL09, P_LF_START, P_VER_WORD, P_VER_MAJOR,
    P_VER_DOT, P_VER_MINOR, P_STATUS, P_MESSAGE, P_LINE, P_NAME, P_LEAD,
    P_VALUE, P_RAW, P_END_LF
  } phase_t;

  typedef logic [POS_BITS-1:0] pos_t;

  phase_t     phase_r, phase_nxt, ph;
  pos_t       tok_r, tok_nxt, val_r, val_nxt, nend_r, nend_nxt;
  logic [8:0] cand_r, cand_nxt;
  logic [2:0] midx_r, midx_nxt;
  logic [1:0] vmaj_r, vmaj_nxt, vcode_r, vcode_nxt, dcnt_r, dcnt_nxt;
  logic [9:0] stat_r, stat_nxt;
  logic [7:0] hdr_r, hdr_nxt;
  logic       cr_r, cr_nxt, empty_r, empty_nxt, done_r, done_nxt;
  hhp_out_t   res, out_r;
  logic       have, ovalid_r, fire;
  logic [7:0] c, lc;
  pos_t       pos;
  logic [8:0] keep;
  logic [3:0] msel;

  // Output register frees while its result is taken.
  assign tok_ready = !ovalid_r || out_ready;
  assign fire      = tok_valid && tok_ready;
  assign out_valid = ovalid_r;
  assign out_data  = out_r;
  assign c   = tok_data.byte_req;
  assign pos = tok_data.pos[POS_BITS-1:0];
  assign lc  = (c >= "A" && c <= "Z") ? c + 8'd32 : c;

  always_comb begin
    msel = 4'd8;
    for (int m = 7; m >= 0; m--) if (cand_r[m]) msel = 4'(m);
  end

  always_comb begin
    phase_nxt = phase_r; tok_nxt = tok_r; val_nxt = val_r; nend_nxt = nend_r;
    cand_nxt = cand_r; midx_nxt = midx_r; vmaj_nxt = vmaj_r; vcode_nxt = vcode_r;
    dcnt_nxt = dcnt_r; stat_nxt = stat_r; hdr_nxt = hdr_r; cr_nxt = cr_r;
    empty_nxt = empty_r; done_nxt = done_r;
    res = '0; have = 1'b0; keep = '0; ph = phase_r;
    if (!done_r) begin
      if (phase_r == P_START) begin
        midx_nxt = '0;
        if (parse_mode) ph = P_VER_WORD;
        else if (c != "/") ph = P_METHOD;
        phase_nxt = ph;
      end
      if (phase_r == P_START && !parse_mode && c == "/") begin
        cand_nxt = 9'd1; vcode_nxt = 2'd0; tok_nxt = pos; phase_nxt = P_URL09;
      end else begin
        case (ph)
          P_METHOD: begin
            if (is_letter(c)) begin
              if (midx_r < 3'd7)
                for (int m = 0; m < 9; m++)
                  keep[m] = cand_r[m] && midx_r < method_len(m)
                            && method_char(m, midx_r) == c;
              cand_nxt = keep;
              if (keep == '0) begin
                have = 1'b1; res.kind = KIND_ERR; res.error_code = ERR_METHOD;
              end else if (midx_r < 3'd7) midx_nxt = midx_r + 3'd1;
            end else begin
              for (int m = 0; m < 9; m++)
                keep[m] = cand_r[m] && method_len(m) == midx_r;
              if (keep == '0) begin
                have = 1'b1; res.kind = KIND_ERR; res.error_code = ERR_METHOD;
              end else if (c != " ") begin
                have = 1'b1; res.kind = KIND_ERR; res.error_code = ERR_SEP;
              end else begin
                cand_nxt = keep; phase_nxt = P_URL; tok_nxt = pos + 1'b1;
                empty_nxt = 1'b1;
              end
            end
          end
          P_URL: begin
            if (c == " ") begin
              if (empty_r) begin
                have = 1'b1; res.kind = KIND_ERR; res.error_code = ERR_URL;
              end else begin
                val_nxt = pos; midx_nxt = '0; phase_nxt = P_VER_WORD;
              end
            end else empty_nxt = 1'b0;
          end
          P_URL09: begin
            if (c == "\r") begin
              val_nxt = pos; phase_nxt = P_LF_START;
            end else if (c == " ") begin
              have = 1'b1; res.kind = KIND_ERR; res.error_code = ERR_SEP;
            end
          end
          P_LF_START: begin
            have = 1'b1;
            if (c != "\n") begin
              res.kind = KIND_ERR; res.error_code = ERR_SEP;
            end else begin
              res.kind = KIND_START;
              if (!parse_mode) res.method = msel;
              else res.status_num = stat_r;
              res.version = vcode_r;
              res.span_offset = 16'(tok_r);
              res.span_length = 16'(pos_t'(val_r - tok_r));
              phase_nxt = P_LINE;
            end
          end
          P_VER_WORD: begin
            if (is_letter(c)) begin
              if (midx_r >= 3'd4 || lc != 8'("http" >> (8 * (3 - int'(midx_r[1:0]))))) begin
                have = 1'b1; res.kind = KIND_ERR; res.error_code = ERR_VER;
              end else midx_nxt = midx_r + 3'd1;
            end else if (midx_r != 3'd4 || c != "/") begin
              have = 1'b1; res.kind = KIND_ERR; res.error_code = ERR_VER;
            end else phase_nxt = P_VER_MAJOR;
          end
          P_VER_MAJOR: begin
            if (c < "0" || c > "2") begin
              have = 1'b1; res.kind = KIND_ERR; res.error_code = ERR_VER;
            end else begin
              vmaj_nxt = 2'(c - "0"); phase_nxt = P_VER_DOT;
            end
          end
          P_VER_DOT: begin
            if (c != ".") begin
              have = 1'b1; res.kind = KIND_ERR; res.error_code = ERR_VER;
            end else begin
              dcnt_nxt = '0; phase_nxt = P_VER_MINOR;
            end
          end
          P_VER_MINOR: begin
            if (is_digit(c)) begin
              if (dcnt_r == 2'd0)
                vcode_nxt = (vmaj_r == 2'd0) ? 2'd0 :
                            (vmaj_r == 2'd1 && c == "0") ? 2'd1 : 2'd2;
              dcnt_nxt = 2'd1;
            end else begin
              if (dcnt_r == 2'd0) vcode_nxt = (vmaj_r == 2'd0) ? 2'd0 : 2'd2;
              if (!parse_mode) begin
                if (c != "\r") begin
                  have = 1'b1; res.kind = KIND_ERR; res.error_code = ERR_SEP;
                end else phase_nxt = P_LF_START;
              end else begin
                if (c != " ") begin
                  have = 1'b1; res.kind = KIND_ERR; res.error_code = ERR_SEP;
                end else begin
                  dcnt_nxt = '0; stat_nxt = '0; phase_nxt = P_STATUS;
                end
              end
            end
          end
          P_STATUS: begin
            if (is_digit(c)) begin
              if (dcnt_r == 2'd3 || (dcnt_r == 2'd0 && (c < "1" || c > "5"))) begin
                have = 1'b1; res.kind = KIND_ERR; res.error_code = ERR_STATUS;
              end else begin
                stat_nxt = 10'((stat_r << 3) + (stat_r << 1) + 10'(c - "0"));
                dcnt_nxt = dcnt_r + 2'd1;
              end
            end else if (dcnt_r != 2'd3) begin
              have = 1'b1; res.kind = KIND_ERR; res.error_code = ERR_STATUS;
            end else if (c != " ") begin
              have = 1'b1; res.kind = KIND_ERR; res.error_code = ERR_SEP;
            end else begin
              tok_nxt = pos + 1'b1; cr_nxt = 1'b0; phase_nxt = P_MESSAGE;
            end
          end
          P_MESSAGE: begin
            if (cr_r && c == "\n") begin
              have = 1'b1;
              res.kind = KIND_START;
              if (!parse_mode) res.method = msel;
              else res.status_num = stat_r;
              res.version = vcode_r;
              res.span_offset = 16'(tok_r);
              res.span_length = 16'(pos_t'(pos - 1'b1 - tok_r));
              phase_nxt = P_LINE;
            end else cr_nxt = (c == "\r");
          end
          P_LINE: begin
            cr_nxt = 1'b0;
            if (c == "\r") phase_nxt = P_END_LF;
            else if (!field_results) phase_nxt = P_RAW;
            else begin
              tok_nxt = pos;
              if (c == ":") begin
                nend_nxt = pos; phase_nxt = P_LEAD;
              end else if (!(is_letter(c) || is_digit(c) || c == "-")) begin
                have = 1'b1; res.kind = KIND_ERR; res.error_code = ERR_COLON;
              end else phase_nxt = P_NAME;
            end
          end
          P_NAME: begin
            if (c == ":") begin
              nend_nxt = pos; phase_nxt = P_LEAD;
            end else if (!(is_letter(c) || is_digit(c) || c == "-")) begin
              have = 1'b1; res.kind = KIND_ERR; res.error_code = ERR_COLON;
            end
          end
          P_LEAD: begin
            if (c != " ") begin
              val_nxt = pos; cr_nxt = (c == "\r"); phase_nxt = P_VALUE;
            end
          end
          P_VALUE, P_RAW: begin
            if (cr_r && c == "\n") begin
              if (hdr_r != 8'hFF) hdr_nxt = hdr_r + 8'd1;
              cr_nxt = 1'b0; phase_nxt = P_LINE;
              if (ph == P_VALUE && field_results) begin
                have = 1'b1; res.kind = KIND_FIELD;
                res.span_offset  = 16'(tok_r);
                res.span_length  = 16'(pos_t'(nend_r - tok_r));
                res.value_offset = 16'(val_r);
                res.value_length = 16'(pos_t'(pos - 1'b1 - val_r));
                res.header_count = hdr_nxt;
              end
            end else cr_nxt = (c == "\r");
          end
          P_END_LF: begin
            have = 1'b1;
            if (c != "\n") begin
              res.kind = KIND_ERR; res.error_code = ERR_SEP;
            end else begin
              res.kind = KIND_END; res.header_count = hdr_r;
              res.body_offset = 16'((pos != '1) ? pos + 1'b1 : pos);
            end
          end
          default: begin
            have = 1'b1; res.kind = KIND_ERR; res.error_code = ERR_SEP;
          end
        endcase
      end
      if (have && (res.kind == KIND_ERR || res.kind == KIND_END)) done_nxt = 1'b1;
      if (tok_data.last && !done_nxt) begin
        res = '0; have = 1'b1; res.kind = KIND_ERR; res.error_code = ERR_TRUNC;
      end
    end
    if (tok_data.last) begin
      phase_nxt = P_START; tok_nxt = '0; val_nxt = '0; nend_nxt = '0;
      cand_nxt = '1; midx_nxt = '0; vmaj_nxt = '0; vcode_nxt = '0;
      stat_nxt = '0; dcnt_nxt = '0; hdr_nxt = '0; cr_nxt = 1'b0;
      empty_nxt = 1'b1; done_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && have) out_r <= res;
    if (!rst_n) begin
      phase_r <= P_START; tok_r <= '0; val_r <= '0; nend_r <= '0;
      cand_r <= '1; midx_r <= '0; vmaj_r <= '0; vcode_r <= '0; stat_r <= '0;
      dcnt_r <= '0; hdr_r <= '0; cr_r <= 1'b0; empty_r <= 1'b1; done_r <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      if (fire) begin
        phase_r <= phase_nxt; tok_r <= tok_nxt; val_r <= val_nxt; nend_r <= nend_nxt;
        cand_r <= cand_nxt; midx_r <= midx_nxt; vmaj_r <= vmaj_nxt;
        vcode_r <= vcode_nxt; stat_r <= stat_nxt; dcnt_r <= dcnt_nxt;
        hdr_r <= hdr_nxt; cr_r <= cr_nxt; empty_r <= empty_nxt; done_r <= done_nxt;
      end
      if (fire) ovalid_r <= have;
      else if (out_ready) ovalid_r <= 1'b0;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (fire && tok_data.last) |=> (phase_r == P_START && !done_r))
    else $error("message end did not restart parser");
  assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && !out_ready) |=> ($stable(out_r) && ovalid_r))
    else $error("held result changed");
  assert property (@(posedge clk) disable iff (!rst_n)
    (fire && done_r && !tok_data.last) |=> !ovalid_r)
    else $error("result after head end");
endmodule
